/* rtl/ckb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ckb_pkg;

    // Pixel and coordinate sizing
    localparam int PIXEL_BITS = 32;
    localparam int COORD_BITS = 12;
    localparam int POS_BITS   = COORD_BITS + 1;          // signed screen origin
    localparam int SUM_BITS   = COORD_BITS + 2;          // origin + window offset
    localparam int BASE_BITS  = 2 * POS_BITS;            // signed row base index
    localparam int INDEX_BITS = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Only the low PIXEL_BITS of a pixel take part
    localparam logic [31:0] PIXEL_MASK = 32'((64'd1 << PIXEL_BITS) - 64'd1);

    // Register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_DEST_X        = 3'd2,
        REG_DEST_Y        = 3'd3,
        REG_WINDOW_WIDTH  = 3'd4,
        REG_WINDOW_HEIGHT = 3'd5,
        REG_KEY_COLOR     = 3'd6
    } cfg_reg_t;

    // Current register contents, fanned out to the datapath
    typedef struct packed {
        logic        [COORD_BITS-1:0] screen_width;
        logic        [COORD_BITS-1:0] screen_height;
        logic signed [POS_BITS-1:0]   dest_x;
        logic signed [POS_BITS-1:0]   dest_y;
        logic        [COORD_BITS-1:0] window_width;
        logic        [COORD_BITS-1:0] window_height;
        logic        [31:0]           key_color;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/ckb_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module ckb_cfg_regs
    import ckb_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[COORD_BITS-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[COORD_BITS-1:0];
                REG_DEST_X:        cfg_next.dest_x        = $signed(cfg_data[POS_BITS-1:0]);
                REG_DEST_Y:        cfg_next.dest_y        = $signed(cfg_data[POS_BITS-1:0]);
                REG_WINDOW_WIDTH:  cfg_next.window_width  = cfg_data[COORD_BITS-1:0];
                REG_WINDOW_HEIGHT: cfg_next.window_height = cfg_data[COORD_BITS-1:0];
                REG_KEY_COLOR:     cfg_next.key_color     = cfg_data[31:0];
                default:           cfg_next = cfg_reg;  // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= COORD_BITS'(320);
            cfg_reg.screen_height <= COORD_BITS'(240);
            cfg_reg.dest_x        <= '0;
            cfg_reg.dest_y        <= '0;
            cfg_reg.window_width  <= COORD_BITS'(1);
            cfg_reg.window_height <= COORD_BITS'(1);
            cfg_reg.key_color     <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/color_key_sprite_blit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A beat accepted on s_ is registered and shows on m_ in the following cycle.
// Throughput: one pixel per cycle; the single result register refills on the
// same edge it drains, so s_ready stays high while m_ is taken every cycle.
// Reset (aresetn low, synchronous): registers return to 320x240 screen, 1x1
// window at origin, key 0; window counters and row base clear; m_valid drops.

module color_key_sprite_blit
    import ckb_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // configuration writes
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    // source pixels
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [31:0]              s_pixel_in,
    input  wire logic                     s_first_pixel,
    // framebuffer writes
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_write_enable,
    output logic [INDEX_BITS-1:0]         m_dest_index,
    output logic [31:0]                   m_pixel_out,
    output logic                          m_window_done
);

    cfg_t cfg;

    ckb_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Window walk state
    logic [COORD_BITS-1:0]       col_reg, col_next;
    logic [COORD_BITS-1:0]       row_reg, row_next;
    logic signed [BASE_BITS-1:0] base_reg, base_next;

    // Result register
    logic                  m_valid_reg, m_valid_next;
    logic                  wen_reg, wen_next;
    logic [INDEX_BITS-1:0] index_reg, index_next;
    logic [31:0]           pix_reg, pix_next;
    logic                  done_reg, done_next;

    logic                        s_beat;
    logic signed [BASE_BITS-1:0] start_base;
    logic [COORD_BITS-1:0]       col_cur, row_cur;
    logic signed [BASE_BITS-1:0] base_cur;
    logic signed [SUM_BITS-1:0]  scol, srow;
    logic                        on_screen, opaque, row_end, win_end;
    logic [31:0]                 pix;
    logic signed [BASE_BITS-1:0] index_sum;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;

    // Row base of the window's top row
    assign start_base = BASE_BITS'(cfg.dest_y) *
                        BASE_BITS'($signed({1'b0, cfg.screen_width}));

    // A start flag restarts the walk before this pixel is placed
    assign col_cur  = s_first_pixel ? '0 : col_reg;
    assign row_cur  = s_first_pixel ? '0 : row_reg;
    assign base_cur = s_first_pixel ? start_base : base_reg;

    // Screen position and clip test
    assign scol = SUM_BITS'(cfg.dest_x) + $signed({2'b00, col_cur});
    assign srow = SUM_BITS'(cfg.dest_y) + $signed({2'b00, row_cur});
    assign on_screen = !scol[SUM_BITS-1] &&
                       (scol[POS_BITS-1:0] < {1'b0, cfg.screen_width}) &&
                       !srow[SUM_BITS-1] &&
                       (srow[POS_BITS-1:0] < {1'b0, cfg.screen_height});

    // Key compare
    assign pix    = s_pixel_in & PIXEL_MASK;
    assign opaque = pix != (cfg.key_color & PIXEL_MASK);

    // Row and window ends; a zero size behaves as one
    assign row_end = ({1'b0, col_cur} + POS_BITS'(1)) >= {1'b0, cfg.window_width};
    assign win_end = row_end &&
                     (({1'b0, row_cur} + POS_BITS'(1)) >= {1'b0, cfg.window_height});

    assign index_sum = base_cur + BASE_BITS'(scol);

    // Counter update
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (s_beat) begin
            if (win_end) begin
                col_next  = '0;
                row_next  = '0;
                base_next = start_base;
            end else if (row_end) begin
                col_next  = '0;
                row_next  = row_cur + COORD_BITS'(1);
                base_next = base_cur + $signed({{(BASE_BITS-COORD_BITS){1'b0}},
                                                cfg.screen_width});
            end else begin
                col_next  = col_cur + COORD_BITS'(1);
                row_next  = row_cur;
                base_next = base_cur;
            end
        end
    end

    // Result register load
    always_comb begin
        m_valid_next = m_valid_reg;
        wen_next     = wen_reg;
        index_next   = index_reg;
        pix_next     = pix_reg;
        done_next    = done_reg;
        if (s_beat) begin
            m_valid_next = 1'b1;
            wen_next     = on_screen && opaque;
            index_next   = on_screen ? index_sum[INDEX_BITS-1:0] : '0;
            pix_next     = pix;
            done_next    = win_end;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            base_reg    <= base_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wen_reg   <= wen_next;
        index_reg <= index_next;
        pix_reg   <= pix_next;
        done_reg  <= done_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = wen_reg;
    assign m_dest_index   = index_reg;
    assign m_pixel_out    = pix_reg;
    assign m_window_done  = done_reg;

    // An accepted pixel always leaves a result behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> m_valid)
        else $error("accepted pixel produced no result");

    // Window end sends the walk back to the top left corner
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && win_end |=> col_reg == '0 && row_reg == '0)
        else $error("counters not cleared at window end");

    // Mid-row pixel advances the column by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && !row_end |=> col_reg == $past(col_cur) + COORD_BITS'(1))
        else $error("column did not advance");

endmodule

`default_nettype wire
